// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/cds_pkg.sv =====
// types and constants of the capacitor discharge sequencer
// no dependencies
package cds_pkg;

    localparam int unsigned MV_W    = 13;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned ROUND_W = 4;
    localparam int unsigned NPINS   = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATER_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS   = 3'd4;

    // register reset values
    localparam logic [MV_W-1:0]    RST_EMPTY_LEVEL = 13'd4;
    localparam logic [MV_W-1:0]    RST_FIRST_LEVEL = 13'd1000;
    localparam logic [MV_W-1:0]    RST_LATER_LEVEL = 13'd1300;
    localparam logic [CNT_W-1:0]   RST_MAX_SAMPLES = 10'd500;
    localparam logic [ROUND_W-1:0] RST_MAX_ROUNDS  = 4'd10;

    // empty margin used for the end-of-round test
    localparam logic [MV_W:0] EMPTY_MARGIN = 14'd2;

    // command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_RUNNING   = 2'd0;
    localparam logic [1:0] STATUS_RELEASED  = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FIRST = 4'b0010,
        PH_DISCH = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [MV_W-1:0]    empty_level;
        logic [MV_W:0]      empty_level2;
        logic [MV_W-1:0]    first_level;
        logic [MV_W-1:0]    later_level;
        logic [CNT_W-1:0]   max_samples;
        logic [ROUND_W-1:0] max_rounds;
    } cfg_t;

    // per-pin compare results from one lane
    typedef struct packed {
        logic below_empty;
        logic below_empty2;
        logic below_first;
        logic below_later;
    } lane_flags_t;

    typedef struct packed {
        logic [NPINS-1:0] direct_mask;
        logic             resistors_on;
        logic [1:0]       status;
        logic             cell_flag;
        logic [CNT_W-1:0] hold_ms;
    } result_t;

endpackage

// ===== hdl/cds_pin_lane.sv =====
// one pin lane: compares a pin voltage against all levels
// depends on cds_pkg
module cds_pin_lane (
    input  logic [cds_pkg::MV_W-1:0] mv,
    input  cds_pkg::cfg_t            cfg,
    output cds_pkg::lane_flags_t     flags
);

    // threshold compares, empty+2 kept one bit wider so it cannot wrap
    always_comb
    begin
        flags.below_empty  = mv < cfg.empty_level;
        flags.below_empty2 = {1'b0, mv} < cfg.empty_level2;
        flags.below_first  = mv < cfg.first_level;
        flags.below_later  = mv < cfg.later_level;
    end

endmodule

// ===== hdl/cds_merge.sv =====
// merge stage: combines lane flags, holds run state and forms the result
// depends on cds_pkg
module cds_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 cmd,
    input  logic                                 cell_known,
    input  cds_pkg::lane_flags_t [cds_pkg::NPINS-1:0] flags,
    input  cds_pkg::cfg_t                        cfg,
    output cds_pkg::result_t                     result
);

    cds_pkg::phase_t                 phase_reg, phase_next;
    logic [cds_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic [cds_pkg::CNT_W-1:0]       sample_reg, sample_next;
    logic [cds_pkg::NPINS-1:0]       mask_reg, mask_next;
    logic                            cell_reg, cell_next;
    logic                            pull_reg, pull_next;

    logic [cds_pkg::NPINS-1:0]       empty_bits, empty2_bits, first_bits, later_bits;
    logic [cds_pkg::CNT_W-1:0]       sample_limit, sample_inc;
    logic [cds_pkg::ROUND_W-1:0]     round_limit, round_inc;
    logic                            round_end;
    logic [1:0]                      status;
    logic [cds_pkg::CNT_W-1:0]       hold;
    logic [cds_pkg::NPINS-1:0]       shown_mask;

    // gather lane flags into masks
    always_comb
    begin
        for (int i = 0; i < cds_pkg::NPINS; i++)
        begin
            empty_bits[i]  = flags[i].below_empty;
            empty2_bits[i] = flags[i].below_empty2;
            first_bits[i]  = flags[i].below_first;
            later_bits[i]  = flags[i].below_later;
        end
    end

    // zero limits behave as one
    assign sample_limit = (cfg.max_samples == '0) ? cds_pkg::CNT_W'(1) : cfg.max_samples;
    assign round_limit  = (cfg.max_rounds == '0) ? cds_pkg::ROUND_W'(1) : cfg.max_rounds;
    assign sample_inc   = sample_reg + cds_pkg::CNT_W'(1);

    // next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        round_next  = round_reg;
        sample_next = sample_reg;
        mask_next   = mask_reg;
        cell_next   = cell_reg;
        pull_next   = pull_reg;
        status      = cds_pkg::STATUS_RUNNING;
        hold        = '0;
        round_end   = 1'b0;
        round_inc   = round_reg + cds_pkg::ROUND_W'(1);

        if (cmd == cds_pkg::CMD_START)
        begin
            cell_next   = cell_known;
            round_next  = '0;
            sample_next = '0;
            mask_next   = '0;
            pull_next   = 1'b1;
            phase_next  = cds_pkg::PH_FIRST;
        end
        else
        begin
            unique case (phase_reg)
                cds_pkg::PH_FIRST:
                begin
                    if (cell_reg || (&empty_bits))
                    begin
                        mask_next  = '0;
                        pull_next  = 1'b0;
                        phase_next = cds_pkg::PH_IDLE;
                        status     = cds_pkg::STATUS_RELEASED;
                    end
                    else
                    begin
                        mask_next   = first_bits;
                        sample_next = '0;
                        phase_next  = cds_pkg::PH_DISCH;
                    end
                end
                cds_pkg::PH_DISCH:
                begin
                    mask_next = mask_reg | later_bits;
                    if (&empty2_bits)
                    begin
                        hold      = sample_reg;
                        round_end = 1'b1;
                    end
                    else
                    begin
                        sample_next = sample_inc;
                        if (sample_inc >= sample_limit)
                        begin
                            // timeout marks a charged cell
                            cell_next = 1'b1;
                            hold      = sample_inc;
                            round_end = 1'b1;
                        end
                    end
                end
                cds_pkg::PH_DONE:
                begin
                    status = cds_pkg::STATUS_EXHAUSTED;
                end
                cds_pkg::PH_IDLE:
                begin
                    status = cds_pkg::STATUS_RELEASED;
                end
                default:
                begin
                    status = cds_pkg::STATUS_RELEASED;
                end
            endcase
        end

        shown_mask = mask_next;

        // round end: either start the next round or stop the run
        if (round_end)
        begin
            round_next  = round_inc;
            sample_next = '0;
            if (round_inc >= round_limit)
            begin
                phase_next = cds_pkg::PH_DONE;
                status     = cds_pkg::STATUS_EXHAUSTED;
            end
            else
            begin
                mask_next  = '0;
                phase_next = cds_pkg::PH_FIRST;
            end
        end

        result.direct_mask  = shown_mask;
        result.resistors_on = pull_next;
        result.status       = status;
        result.cell_flag    = cell_next;
        result.hold_ms      = hold;
    end

    // run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cds_pkg::PH_IDLE;
            round_reg  <= '0;
            sample_reg <= '0;
            mask_reg   <= '0;
            cell_reg   <= 1'b0;
            pull_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            round_reg  <= round_next;
            sample_reg <= sample_next;
            mask_reg   <= mask_next;
            cell_reg   <= cell_next;
            pull_reg   <= pull_next;
        end
    end

endmodule

// ===== hdl/capacitor_discharge_sequencer.sv =====
// top level of the capacitor discharge sequencer
// depends on cds_pkg, cds_pin_lane, cds_merge
//
// usage:
// - input channel (in_valid/in_ready) takes one request per item: cmd 0
//   starts a run with cell_known, cmd 1 delivers pin1_mv..pin3_mv
// - output channel (out_valid/out_ready) returns exactly one result per
//   request: direct_mask, resistors_on, status, cell_flag, hold_ms
// - out_valid rises in the cycle after acceptance; throughput is one
//   request per cycle while the receiver does not stall, set by the single
//   output register after the three pin lanes and the merge stage
// - when the receiver stalls the result holds in the output register and
//   in_ready drops until it is taken; in_ready is high whenever the output
//   register is empty or being drained in the same cycle
// - configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next clock edge; indexes past the last register are ignored
// - reset clears the run state (idle, status released), the output
//   register valid bit, and loads the default register values
module capacitor_discharge_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cds_pkg::MV_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic                              cell_known,
    input  logic [cds_pkg::MV_W-1:0]          pin1_mv,
    input  logic [cds_pkg::MV_W-1:0]          pin2_mv,
    input  logic [cds_pkg::MV_W-1:0]          pin3_mv,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cds_pkg::NPINS-1:0]         direct_mask,
    output logic                              resistors_on,
    output logic [1:0]                        status,
    output logic                              cell_flag,
    output logic [cds_pkg::CNT_W-1:0]         hold_ms
);

    logic [cds_pkg::MV_W-1:0]    empty_reg, first_reg, later_reg;
    logic [cds_pkg::CNT_W-1:0]   max_samples_reg;
    logic [cds_pkg::ROUND_W-1:0] max_rounds_reg;

    cds_pkg::cfg_t                              cfg;
    logic [cds_pkg::MV_W-1:0]                   pin_mv [cds_pkg::NPINS];
    cds_pkg::lane_flags_t [cds_pkg::NPINS-1:0]  flags;
    cds_pkg::result_t                           result;
    cds_pkg::result_t                           out_reg;
    logic                                       out_valid_reg, out_valid_next;
    logic                                       accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg       <= cds_pkg::RST_EMPTY_LEVEL;
            first_reg       <= cds_pkg::RST_FIRST_LEVEL;
            later_reg       <= cds_pkg::RST_LATER_LEVEL;
            max_samples_reg <= cds_pkg::RST_MAX_SAMPLES;
            max_rounds_reg  <= cds_pkg::RST_MAX_ROUNDS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cds_pkg::REG_EMPTY_LEVEL: empty_reg       <= cfg_data;
                cds_pkg::REG_FIRST_LEVEL: first_reg       <= cfg_data;
                cds_pkg::REG_LATER_LEVEL: later_reg       <= cfg_data;
                cds_pkg::REG_MAX_SAMPLES: max_samples_reg <= cfg_data[cds_pkg::CNT_W-1:0];
                cds_pkg::REG_MAX_ROUNDS:  max_rounds_reg  <= cfg_data[cds_pkg::ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // thresholds seen by the lanes
    always_comb
    begin
        cfg.empty_level  = empty_reg;
        cfg.empty_level2 = {1'b0, empty_reg} + cds_pkg::EMPTY_MARGIN;
        cfg.first_level  = first_reg;
        cfg.later_level  = later_reg;
        cfg.max_samples  = max_samples_reg;
        cfg.max_rounds   = max_rounds_reg;
    end

    assign pin_mv[0] = pin1_mv;
    assign pin_mv[1] = pin2_mv;
    assign pin_mv[2] = pin3_mv;

    // one compare lane per pin
    for (genvar g = 0; g < cds_pkg::NPINS; g++)
    begin : g_lane
        cds_pin_lane u_lane (
            .mv    (pin_mv[g]),
            .cfg   (cfg),
            .flags (flags[g])
        );
    end

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // merge stage with run state
    cds_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .cell_known (cell_known),
        .flags      (flags),
        .cfg        (cfg),
        .result     (result)
    );

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign direct_mask  = out_reg.direct_mask;
    assign resistors_on = out_reg.resistors_on;
    assign status       = out_reg.status;
    assign cell_flag    = out_reg.cell_flag;
    assign hold_ms      = out_reg.hold_ms;

endmodule

// ===== hdl/cds_checker.sv =====
// port-level checker for the capacitor discharge sequencer, with its bind
// depends on cds_pkg, assert_macros.svh, capacitor_discharge_sequencer
`include "assert_macros.svh"

module cds_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              cmd,
    input logic                              cell_known,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [cds_pkg::NPINS-1:0]         direct_mask,
    input logic                              resistors_on,
    input logic [1:0]                        status,
    input logic                              cell_flag,
    input logic [cds_pkg::CNT_W-1:0]         hold_ms
);

    // stalled result holds
    `CDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({direct_mask, resistors_on, status, cell_flag, hold_ms}))

    // input side only blocks while a result is stuck
    `CDS_ASSERT_SAME(a_ready_rule, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))

    // a start request opens a run with resistors on and no direct ground
    `CDS_ASSERT_NEXT(a_start_result, clk, rst_n, in_valid && in_ready && (cmd == cds_pkg::CMD_START), out_valid && resistors_on && (direct_mask == '0) && (status == cds_pkg::STATUS_RUNNING) && (cell_flag == $past(cell_known)))

    // released runs have all pins let go
    `CDS_ASSERT_SAME(a_released_clear, clk, rst_n, out_valid && (status == cds_pkg::STATUS_RELEASED), !resistors_on && (direct_mask == '0) && (hold_ms == '0))

endmodule

bind capacitor_discharge_sequencer cds_checker u_cds_checker (.*);
